/* src/ousv_pkg.sv */
package ousv_pkg;

   // default store geometry
   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // fixed field widths of the request and response
   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // control sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // strobes broadcast from the sequencer to every cell
   typedef struct packed {
      logic compare;
      logic append;
      logic remove;
   } cell_ctrl_type;

   // response payload, status in the lowest bits
   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic [VALUE_W-1:0] read_value;
      logic [POS_W-1:0]   found_position;
      logic               found;
      status_type         status;
   } rsp_type;

endpackage

/* src/ousv_cell.sv */
module ousv_cell #(
   parameter int VALUE_WIDTH = ousv_pkg::VALUE_WIDTH_DEFAULT,
   parameter int IDX_W       = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ousv_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]        idx,
   input  logic [IDX_W:0]          count,
   input  logic [VALUE_WIDTH-1:0]  key,
   input  logic [ousv_pkg::POS_W-1:0] pos,
   input  logic [VALUE_WIDTH-1:0]  next_value,
   input  logic                    seen_in,
   output logic                    seen_out,
   output logic                    hit,
   output logic [VALUE_WIDTH-1:0]  value,
   output logic [VALUE_WIDTH-1:0]  rd_value
);
   import ousv_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] rd_ff;
   logic                   hit_ff;
   logic [IDX_W:0]         idx_c;
   logic [IDX_W+POS_W-1:0] idx_p, pos_p;
   logic                   occupied;

   // index widened for the count and position compares
   assign idx_c    = {1'b0, idx};
   assign idx_p    = {{POS_W{1'b0}}, idx};
   assign pos_p    = {{IDX_W{1'b0}}, pos};
   assign occupied = idx_c < count;

   // shift down once a hit is seen at or below this place
   assign seen_out = seen_in | hit_ff;

   // next entry value: append at the tail or take the upper neighbor
   always_comb begin
      value_in = value_ff;
      if (ctrl.append && (idx_c == count)) begin
         value_in = key;
      end else if (ctrl.remove && seen_out) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // match and read capture on request accept
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctrl.compare) begin
         hit_ff <= occupied && (value_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         rd_ff <= (idx_p == pos_p) ? value_ff : '0;
      end
   end

   assign hit      = hit_ff;
   assign value    = value_ff;
   assign rd_value = rd_ff;

endmodule

/* src/ousv_chain.sv */
module ousv_chain #(
   parameter int DEPTH       = ousv_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = ousv_pkg::VALUE_WIDTH_DEFAULT,
   parameter int IDX_W       = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ousv_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W:0]          count,
   input  logic [VALUE_WIDTH-1:0]  key,
   input  logic [ousv_pkg::POS_W-1:0] pos,
   output logic                    found,
   output logic [IDX_W-1:0]        found_pos,
   output logic [VALUE_WIDTH-1:0]  read_value
);
   import ousv_pkg::*;

   logic [VALUE_WIDTH-1:0] value [DEPTH];
   logic [VALUE_WIDTH-1:0] rd    [DEPTH];
   logic [VALUE_WIDTH-1:0] upper [DEPTH];
   logic [DEPTH:0]         seen;
   logic [DEPTH-1:0]       hit;

   assign seen[0] = 1'b0;

   // row of cells, each linked to its upper neighbor
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi < DEPTH - 1) begin : g_mid
         assign upper[gi] = value[gi+1];
      end else begin : g_last
         assign upper[gi] = value[gi];
      end

      ousv_cell #(
         .VALUE_WIDTH(VALUE_WIDTH),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .idx       (IDX_W'(gi)),
         .count     (count),
         .key       (key),
         .pos       (pos),
         .next_value(upper[gi]),
         .seen_in   (seen[gi]),
         .seen_out  (seen[gi+1]),
         .hit       (hit[gi]),
         .value     (value[gi]),
         .rd_value  (rd[gi])
      );
   end

   // values are unique, so at most one cell hits: or-reduce index and data
   always_comb begin
      found      = 1'b0;
      found_pos  = '0;
      read_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found      = found | hit[i];
         found_pos  = found_pos | (hit[i] ? IDX_W'(i) : '0);
         read_value = read_value | rd[i];
      end
   end

endmodule

/* src/ordered_unique_value_set.sv */
// channel  | direction | handshake          | payload
// req      | in        | req_tvalid/tready  | tuser: cmd; tdata: value, position
// rsp      | out       | rsp_tvalid/tready  | tdata: status, found, found_position,
//          |           |                    |        read_value, entry_count
//
// each request has an accept edge and an execute edge: the accept edge compares the key against every
// cell of the row at once, the execute edge applies add/delete and loads the response
// register; delete compacts the row in the execute edge by a neighbor shift
// req_tready is high only while no request is in flight
// a response waiting in the output register stalls only the execute edge
// reset (synchronous, active high) empties the set; cell contents are not cleared
module ordered_unique_value_set #(
   parameter int DEPTH       = ousv_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = ousv_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ousv_pkg::REQ_DATA_W-1:0]   req_tdata,  // value[31:0], position[37:32]
   input  logic [ousv_pkg::CMD_W-1:0]        req_tuser,  // cmd[1:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ousv_pkg::RSP_DATA_W-1:0]   rsp_tdata   // status[1:0], found[2],
                                                         // found_position[8:3],
                                                         // read_value[40:9],
                                                         // entry_count[47:41]
);
   import ousv_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   cell_ctrl_type          ctrl;
   logic                   req_go, exec_go;
   logic [VALUE_W+VALUE_WIDTH-1:0] req_value_ext;
   logic [VALUE_WIDTH-1:0] req_key, cell_key;
   logic                   found;
   logic [IDX_W-1:0]       found_pos;
   logic [VALUE_WIDTH-1:0] read_value;
   logic [IDX_W+POS_W-1:0] fpos_ext;
   logic [VALUE_W+VALUE_WIDTH-1:0] rval_ext;
   logic [CNT_W+COUNT_W-1:0] count_ext;
   logic [CNT_W+POS_W-1:0] pos_w, count_w;

   // request field unpacking
   assign req_value_ext = {{VALUE_WIDTH{1'b0}}, req_tdata[VALUE_W-1:0]};
   assign req_key       = req_value_ext[VALUE_WIDTH-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // compare uses the incoming key, append uses the held one
   assign cell_key = (state_ff == S_IDLE) ? req_key : key_ff;

   ousv_chain #(
      .DEPTH      (DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX_W      (IDX_W)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .count     (count_ff),
      .key       (cell_key),
      .pos       (req_tdata[VALUE_W+POS_W-1:VALUE_W]),
      .found     (found),
      .found_pos (found_pos),
      .read_value(read_value)
   );

   // widened views for output fields and the range check
   assign fpos_ext  = {{POS_W{1'b0}}, found_pos};
   assign rval_ext  = {{VALUE_W{1'b0}}, read_value};
   assign count_ext = {{COUNT_W{1'b0}}, count_in};
   assign pos_w     = {{CNT_W{1'b0}}, pos_ff};
   assign count_w   = {{POS_W{1'b0}}, count_ff};

   // sequencer: next state, cell strobes, store update and response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      ctrl         = '0;
      case (state_ff)
         S_IDLE: begin
            ctrl.compare = req_go;
            if (req_go) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               rsp_in.status         = ST_OK;
               rsp_in.found          = 1'b0;
               rsp_in.found_position = '0;
               rsp_in.read_value     = '0;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (found) begin
                        rsp_in.status = ST_DUP;
                     end else if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ctrl.append = 1'b1;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (found) begin
                        rsp_in.found          = 1'b1;
                        rsp_in.found_position = fpos_ext[POS_W-1:0];
                        ctrl.remove           = 1'b1;
                        count_in              = count_ff - 1'b1;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (found) begin
                        rsp_in.found          = 1'b1;
                        rsp_in.found_position = fpos_ext[POS_W-1:0];
                     end
                  end
                  CMD_READ: begin
                     if (pos_w >= count_w) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        rsp_in.read_value = rval_ext[VALUE_W-1:0];
                     end
                  end
                  default: begin
                     rsp_in.status = ST_OK;
                  end
               endcase
               rsp_in.entry_count = count_ext[COUNT_W-1:0];
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (req_go) begin
         cmd_ff <= cmd_type'(req_tuser);
         key_ff <= req_key;
         pos_ff <= req_tdata[VALUE_W+POS_W-1:VALUE_W];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // count never passes the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond store size");

   // a hit always lies inside the occupied part of the row
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      exec_go && found |-> ({1'b0, found_pos} < count_ff))
      else $error("match outside occupied entries");

   // a duplicate add leaves the count unchanged
   a_dup_keeps: assert property (@(posedge clock) disable iff (reset)
      exec_go && (cmd_ff == CMD_ADD) && found |=> count_ff == $past(count_ff))
      else $error("duplicate add changed the count");

   // a delete hit drops exactly one entry
   a_delete_drops: assert property (@(posedge clock) disable iff (reset)
      exec_go && (cmd_ff == CMD_DELETE) && found
      |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("delete did not drop one entry");

endmodule

/* test/ordered_unique_value_set_tb.sv */
`timescale 1ns / 1ps

module testbench;
   import ousv_pkg::*;

   localparam int SET_DEPTH   = DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int PAD_W       = REQ_DATA_W - VALUE_W - POS_W;

   // shadow of the set contents plus the queue of responses still owed
   class value_set_tracker;
      logic [VALUE_W-1:0] stored [SET_DEPTH];
      int                 held = 0;
      rsp_type            awaited [$];
      int                 errors = 0;
      int                 reported = 0;

      function void complain(string what, logic [RSP_DATA_W-1:0] want,
                             logic [RSP_DATA_W-1:0] got);
         errors++;
         if (reported < 10) begin
            reported++;
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
         end
      endfunction

      // apply one accepted request and queue the response it must produce
      function void note_request(cmd_type cmd, logic [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         rsp_type r;
         int      hit;
         int      i;
         r = '0;
         hit = -1;
         for (i = 0; i < held; i++)
            if (hit < 0 && stored[i] == value) hit = i;
         case (cmd)
            CMD_ADD: begin
               // duplicate wins over full
               if (hit >= 0) r.status = ST_DUP;
               else if (held >= SET_DEPTH) r.status = ST_FULL;
               else begin
                  stored[held] = value;
                  held++;
               end
            end
            CMD_DELETE: begin
               if (hit >= 0) begin
                  r.found = 1'b1;
                  r.found_position = POS_W'(hit);
                  // close the gap, keeping insertion order
                  for (i = hit; i < held - 1; i++) stored[i] = stored[i + 1];
                  held--;
               end
            end
            CMD_LOOKUP: begin
               if (hit >= 0) begin
                  r.found = 1'b1;
                  r.found_position = POS_W'(hit);
               end
            end
            default: begin
               if (int'(pos) >= held) r.status = ST_RANGE;
               else r.read_value = stored[pos];
            end
         endcase
         r.entry_count = COUNT_W'(held);
         awaited.insert(awaited.size(), r);
      endfunction

      // compare one response with the oldest one owed
      function void check_response(logic [RSP_DATA_W-1:0] data);
         rsp_type got;
         rsp_type want;
         got = data;
         if (awaited.size() == 0) begin
            complain("response with no request pending", '0, data);
         end else begin
            want = awaited.pop_front();
            if (got.status != want.status)
               complain("status", RSP_DATA_W'(want.status), RSP_DATA_W'(got.status));
            if (got.found != want.found)
               complain("found", RSP_DATA_W'(want.found), RSP_DATA_W'(got.found));
            if (got.found_position != want.found_position)
               complain("found_position", RSP_DATA_W'(want.found_position),
                        RSP_DATA_W'(got.found_position));
            if (got.read_value != want.read_value)
               complain("read_value", RSP_DATA_W'(want.read_value),
                        RSP_DATA_W'(got.read_value));
            if (got.entry_count != want.entry_count)
               complain("entry_count", RSP_DATA_W'(want.entry_count),
                        RSP_DATA_W'(got.entry_count));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // value[31:0], position[37:32]
   logic [CMD_W-1:0]      req_tuser = '0;  // cmd[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // status, found, found_position,
                                           // read_value, entry_count

   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   value_set_tracker board = new;

   ordered_unique_value_set uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // observe both channels; a response always belongs to an earlier request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            board.note_request(cmd_type'(req_tuser), req_tdata[VALUE_W-1:0],
                               req_tdata[VALUE_W +: POS_W]);
      end
   end

   // stop the run if nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("testbench failed");
      $finish;
   end

   // present one request, with random idle cycles ahead of it
   task automatic send_request(cmd_type cmd, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {{PAD_W{1'b0}}, pos, value};
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off new requests until every owed response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   // either a value held now, a small or high pool value, or anything
   function automatic logic [VALUE_W-1:0] pick_value(int hit_pct);
      if (board.held > 0 && $urandom_range(99) < hit_pct)
         return board.stored[$urandom_range(board.held - 1)];
      case ($urandom_range(2))
         0:       return VALUE_W'($urandom_range(63));
         1:       return ~VALUE_W'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // in range, exactly at the count, or anywhere
   function automatic logic [POS_W-1:0] pick_position();
      int roll;
      roll = $urandom_range(99);
      if (board.held > 0 && roll < 40) return POS_W'($urandom_range(board.held - 1));
      if (roll < 60) return POS_W'(board.held);
      return POS_W'($urandom_range(63));
   endfunction

   // filling runs favor adds, draining runs favor deletes
   task automatic send_random(bit filling);
      int      roll;
      cmd_type cmd;
      roll = $urandom_range(99);
      if (filling)
         cmd = (roll < 60) ? CMD_ADD : (roll < 70) ? CMD_DELETE :
               (roll < 85) ? CMD_LOOKUP : CMD_READ;
      else
         cmd = (roll < 65) ? CMD_DELETE : (roll < 75) ? CMD_ADD :
               (roll < 88) ? CMD_LOOKUP : CMD_READ;
      case (cmd)
         CMD_ADD:    send_request(cmd, pick_value(10), POS_W'($urandom_range(63)));
         CMD_DELETE: send_request(cmd, pick_value(80), POS_W'($urandom_range(63)));
         CMD_LOOKUP: send_request(cmd, pick_value(60), POS_W'($urandom_range(63)));
         default:    send_request(cmd, $urandom, pick_position());
      endcase
   endtask

   initial begin : stimulus
      int phase;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 13;
      recv_stall_pct = 46;

      // empty set: read at the count, misses
      send_request(CMD_READ,   32'h0000_0000, 6'd0);
      send_request(CMD_LOOKUP, 32'h0000_0000, 6'd0);
      send_request(CMD_DELETE, 32'h0000_0005, 6'd63);
      // adds, including extremes and a duplicate
      send_request(CMD_ADD,    32'h0000_0000, 6'd0);
      send_request(CMD_ADD,    32'hFFFF_FFFF, 6'd63);
      send_request(CMD_ADD,    32'h0000_0000, 6'd0);
      send_request(CMD_ADD,    32'h8000_0001, 6'd0);
      send_request(CMD_ADD,    32'h7FFF_FFFE, 6'd0);
      // lookups hit and miss
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);
      send_request(CMD_LOOKUP, 32'h0001_2345, 6'd0);
      // reads in range, at the count and at the top position
      send_request(CMD_READ,   32'h0000_0000, 6'd0);
      send_request(CMD_READ,   32'hFFFF_FFFF, 6'd3);
      send_request(CMD_READ,   32'h0000_0000, 6'd4);
      send_request(CMD_READ,   32'h0000_0000, 6'd63);
      // delete from the middle, then check the shift
      send_request(CMD_DELETE, 32'hFFFF_FFFF, 6'd0);
      send_request(CMD_READ,   32'h0000_0000, 6'd1);
      send_request(CMD_LOOKUP, 32'h7FFF_FFFE, 6'd0);
      // delete first and last, then a miss
      send_request(CMD_DELETE, 32'h0000_0000, 6'd0);
      send_request(CMD_DELETE, 32'h7FFF_FFFE, 6'd0);
      send_request(CMD_DELETE, 32'h7FFF_FFFE, 6'd0);
      // re-add a deleted value, then empty the set again
      send_request(CMD_ADD,    32'hFFFF_FFFF, 6'd0);
      send_request(CMD_READ,   32'h0000_0000, 6'd1);
      send_request(CMD_DELETE, 32'h8000_0001, 6'd0);
      send_request(CMD_DELETE, 32'hFFFF_FFFF, 6'd0);
      send_request(CMD_READ,   32'h0000_0000, 6'd0);
      drain_responses();

      // random traffic under three idle profiles
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 46 : 0;
         recv_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 13 : 0;
         for (n = 0; n < 550; n++) send_random(((n / 150) % 2) == 0);
         drain_responses();
      end

      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

/* sim.f */
src/ousv_pkg.sv
src/ousv_cell.sv
src/ousv_chain.sv
src/ordered_unique_value_set.sv
test/ordered_unique_value_set_tb.sv
